// File: rtl/flow_batch_dispense_controller_core_assert.svh
// assertion macros for the checker file
`ifndef FLOW_BATCH_DISPENSE_CONTROLLER_CORE_ASSERT_SVH
`define FLOW_BATCH_DISPENSE_CONTROLLER_CORE_ASSERT_SVH

// same-cycle implication
`define FBDC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FBDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/fbdc_pkg.sv
// shared types and constants of the batch dispense controller
`timescale 1ns / 1ps
package fbdc_pkg;

  localparam int VOL_W      = 15;
  localparam int UNIT_W     = 16;
  localparam int TICK_W     = 8;
  localparam int FLOW_W     = 20;
  localparam int PHASE_W    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // phase codes
  localparam logic [PHASE_W-1:0] PH_STOP  = 2'd0;
  localparam logic [PHASE_W-1:0] PH_READY = 2'd1;
  localparam logic [PHASE_W-1:0] PH_OPEN  = 2'd2;

  // input mode codes
  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_PRESS = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_UNIT_SMALL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UNIT_LARGE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UNIT_THR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM_THR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_READY_TCK  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_QUAL_TCK   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GLITCH_TCK = 3'd6;

  // register reset values
  localparam logic [UNIT_W-1:0] RST_UNIT_SMALL = 16'd13455;
  localparam logic [UNIT_W-1:0] RST_UNIT_LARGE = 16'd13312;
  localparam logic [VOL_W-1:0]  RST_UNIT_THR   = 15'd300;
  localparam logic [VOL_W-1:0]  RST_TRIM_THR   = 15'd50;
  localparam logic [TICK_W-1:0] RST_READY_TCK  = 8'd100;
  localparam logic [TICK_W-1:0] RST_QUAL_TCK   = 8'd30;
  localparam logic [TICK_W-1:0] RST_GLITCH_TCK = 8'd3;

  // controller to datapath
  typedef struct packed {
    logic take;
    logic div_step;
    logic tgt_en;
    logic mul_en;
    logic fin_en;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_stop;
    logic is_open;
    logic div_last;
  } sts_t;

endpackage

// File: rtl/flow_batch_dispense_controller_core.sv
// top level of the flow-meter batch dispense controller
//
//   channel   direction  handshake              payload
//   in        input      in_valid_i/in_ready_o  mode_i, sensor_level_i, volume_ml_i
//   out       output     out_valid_o/out_ready_i pump_on_o, phase_o, remaining_ml_o,
//                                               flow_count_o, done_res_o
//   cfg       input      cfg_we_i               cfg_idx_i, cfg_wdata_i
//
// one item at a time; a tick while stopped or ready and a stop press go from accept
// straight to output, a tick while open steps through qualify, multiply, remaining and
// target check, and output, and a start press runs the bit-serial divider that forms
// the target count, then sets the target before output
// the output register frees the core: a waiting result stalls only the next result
// reset is asynchronous, active low, and returns the sequencer, batch state and
// settings to their defaults; result and divider registers load before use
`timescale 1ns / 1ps
module flow_batch_dispense_controller_core #(
  parameter int COUNT_WIDTH        = 20,
  parameter int UNIT_FRACTION_BITS = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration writes
  input  logic                            cfg_we_i,
  input  logic [fbdc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fbdc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // input items
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            mode_i,
  input  logic                            sensor_level_i,
  input  logic [fbdc_pkg::VOL_W-1:0]      volume_ml_i,
  // result items
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            pump_on_o,
  output logic [fbdc_pkg::PHASE_W-1:0]    phase_o,
  output logic [fbdc_pkg::VOL_W-1:0]      remaining_ml_o,
  output logic [fbdc_pkg::FLOW_W-1:0]     flow_count_o,
  output logic                            done_res_o
);
  import fbdc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: accept, divide, target, multiply, finish, output
  fbdc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // batch state, qualifier, divider, multiplier and output register
  fbdc_datapath #(
    .COUNT_WIDTH        (COUNT_WIDTH),
    .UNIT_FRACTION_BITS (UNIT_FRACTION_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .mode_i         (mode_i),
    .sensor_level_i (sensor_level_i),
    .volume_ml_i    (volume_ml_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .pump_on_o      (pump_on_o),
    .phase_o        (phase_o),
    .remaining_ml_o (remaining_ml_o),
    .flow_count_o   (flow_count_o),
    .done_res_o     (done_res_o)
  );

endmodule

// File: rtl/fbdc_ctrl.sv
// sequencer of the batch dispense controller
`timescale 1ns / 1ps
module fbdc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          mode_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  fbdc_pkg::sts_t sts_i,
  output fbdc_pkg::cmd_t cmd_o
);
  import fbdc_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_TGT  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;
  localparam logic [2:0] ST_PUT  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (mode_i == MODE_PRESS && sts_i.is_stop) begin
            state_d = ST_DIV;
          end else if (mode_i == MODE_TICK && sts_i.is_open) begin
            state_d = ST_MUL;
          end else begin
            state_d = ST_PUT;
          end
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_TGT;
        end
      end
      ST_TGT: begin
        cmd_o.tgt_en = 1'b1;
        state_d = ST_PUT;
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        cmd_o.fin_en = 1'b1;
        state_d = ST_PUT;
      end
      ST_PUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/fbdc_datapath.sv
// registers, divider, multiplier and edge qualifier of the dispense controller
`timescale 1ns / 1ps
module fbdc_datapath #(
  parameter int COUNT_WIDTH        = 20,
  parameter int UNIT_FRACTION_BITS = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [fbdc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [fbdc_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                mode_i,
  input  logic                                sensor_level_i,
  input  logic [fbdc_pkg::VOL_W-1:0]          volume_ml_i,
  input  fbdc_pkg::cmd_t                      cmd_i,
  output fbdc_pkg::sts_t                      sts_o,
  output logic                                pump_on_o,
  output logic [fbdc_pkg::PHASE_W-1:0]        phase_o,
  output logic [fbdc_pkg::VOL_W-1:0]          remaining_ml_o,
  output logic [fbdc_pkg::FLOW_W-1:0]         flow_count_o,
  output logic                                done_res_o
);
  import fbdc_pkg::*;

  // dividend (volume << (F+1)) + unit and quotient share one register
  localparam int QW    = VOL_W + UNIT_FRACTION_BITS + 2;
  localparam int CNT_W = $clog2(QW);
  localparam int DR_W  = UNIT_W + 1;
  localparam int QX_W  = QW + COUNT_WIDTH;
  localparam int PW    = COUNT_WIDTH + UNIT_W;
  localparam int DW    = PW - UNIT_FRACTION_BITS;
  localparam int EX_W  = COUNT_WIDTH + FLOW_W;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // configuration
  logic [UNIT_W-1:0] unit_small_q, unit_large_q;
  logic [VOL_W-1:0]  unit_thr_q, trim_thr_q;
  logic [TICK_W-1:0] ready_tck_q, qual_tck_q, glitch_tck_q;

  // batch state
  logic [PHASE_W-1:0]     phase_q, phase_d;
  logic [TICK_W-1:0]      cd_q, cd_d;
  logic [VOL_W-1:0]       tv_q, tv_d;
  logic [COUNT_WIDTH-1:0] tgt_q, tgt_d;
  logic [UNIT_W-1:0]      unit_q, unit_d;
  logic [COUNT_WIDTH-1:0] edge_q, edge_d;
  logic [VOL_W-1:0]       rem_q, rem_d;
  logic                   prev_q, prev_d;
  logic                   qual_q, qual_d;
  logic [TICK_W-1:0]      hr_q, hr_d;
  logic [TICK_W-1:0]      lr_q, lr_d;
  logic                   done_q, done_d;

  // divider and multiplier
  logic [QW-1:0]    n_q, n_d;
  logic [DR_W-1:0]  dr_q, dr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [PW-1:0]    prod_q;

  logic [UNIT_W-1:0]  unit_sel;
  logic [DR_W:0]      r_sh, divisor, r_diff;
  logic [QX_W-1:0]    q_ext;
  logic               q_sat;
  logic [COUNT_WIDTH-1:0] tc;
  logic [DW-1:0]      disp;
  logic [EX_W-1:0]    edge_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_small_q <= RST_UNIT_SMALL;
      unit_large_q <= RST_UNIT_LARGE;
      unit_thr_q   <= RST_UNIT_THR;
      trim_thr_q   <= RST_TRIM_THR;
      ready_tck_q  <= RST_READY_TCK;
      qual_tck_q   <= RST_QUAL_TCK;
      glitch_tck_q <= RST_GLITCH_TCK;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_UNIT_SMALL: unit_small_q <= cfg_wdata_i;
        REG_UNIT_LARGE: unit_large_q <= cfg_wdata_i;
        REG_UNIT_THR:   unit_thr_q   <= cfg_wdata_i[VOL_W-1:0];
        REG_TRIM_THR:   trim_thr_q   <= cfg_wdata_i[VOL_W-1:0];
        REG_READY_TCK:  ready_tck_q  <= cfg_wdata_i[TICK_W-1:0];
        REG_QUAL_TCK:   qual_tck_q   <= cfg_wdata_i[TICK_W-1:0];
        REG_GLITCH_TCK: glitch_tck_q <= cfg_wdata_i[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  assign unit_sel = (volume_ml_i <= unit_thr_q) ? unit_small_q : unit_large_q;

  // restoring divide step, divisor is 2 * unit
  assign divisor = {1'b0, unit_q, 1'b0};
  assign r_sh    = {dr_q, n_q[QW-1]};
  assign r_diff  = r_sh - divisor;

  // target count from the quotient: saturate, then trim
  assign q_ext = QX_W'(n_q);
  assign q_sat = (unit_q == '0) || (q_ext[QX_W-1:COUNT_WIDTH] != '0);
  always_comb begin
    tc = q_sat ? COUNT_MAX : q_ext[COUNT_WIDTH-1:0];
    if (tv_q <= trim_thr_q && tc != '0) begin
      tc = tc - 1'b1;
    end
  end

  assign disp = prod_q[PW-1:UNIT_FRACTION_BITS];

  always_comb begin
    phase_d = phase_q;
    cd_d    = cd_q;
    tv_d    = tv_q;
    tgt_d   = tgt_q;
    unit_d  = unit_q;
    edge_d  = edge_q;
    rem_d   = rem_q;
    prev_d  = prev_q;
    qual_d  = qual_q;
    hr_d    = hr_q;
    lr_d    = lr_q;
    done_d  = done_q;
    n_d     = n_q;
    dr_d    = dr_q;
    cnt_d   = cnt_q;

    if (cmd_i.take) begin
      done_d = 1'b0;
      if (mode_i == MODE_PRESS) begin
        if (phase_q == PH_STOP) begin
          unit_d = unit_sel;
          tv_d   = volume_ml_i;
          rem_d  = volume_ml_i;
          cd_d   = ready_tck_q;
          n_d    = (QW'(volume_ml_i) << (UNIT_FRACTION_BITS + 1)) + QW'(unit_sel);
          dr_d   = '0;
          cnt_d  = '0;
        end else begin
          phase_d = PH_STOP;
        end
      end else if (phase_q == PH_READY) begin
        cd_d = cd_q - 1'b1;
        if (cd_d == '0) begin
          phase_d = PH_OPEN;
          edge_d  = '0;
          prev_d  = 1'b0;
          qual_d  = 1'b0;
          hr_d    = '0;
          lr_d    = '0;
        end
      end else if (phase_q == PH_OPEN) begin
        // edge qualifier with glitch discard
        if (sensor_level_i) begin
          if (!prev_q && qual_q && lr_q < glitch_tck_q) begin
            lr_d = '0;
          end
          if (!qual_q) begin
            hr_d = (hr_q != '1) ? hr_q + 1'b1 : hr_q;
            if (hr_d >= qual_tck_q) begin
              hr_d   = '0;
              qual_d = 1'b1;
              edge_d = (edge_q != COUNT_MAX) ? edge_q + 1'b1 : edge_q;
            end
          end
          prev_d = 1'b1;
        end else begin
          if (prev_q && !qual_q && hr_q < glitch_tck_q) begin
            hr_d = '0;
          end
          if (qual_q) begin
            lr_d = (lr_q != '1) ? lr_q + 1'b1 : lr_q;
            if (lr_d >= qual_tck_q) begin
              lr_d   = '0;
              qual_d = 1'b0;
              edge_d = (edge_q != COUNT_MAX) ? edge_q + 1'b1 : edge_q;
            end
          end
          prev_d = 1'b0;
        end
      end
    end

    if (cmd_i.div_step) begin
      if (!r_diff[DR_W]) begin
        dr_d = r_diff[DR_W-1:0];
        n_d  = {n_q[QW-2:0], 1'b1};
      end else begin
        dr_d = r_sh[DR_W-1:0];
        n_d  = {n_q[QW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
    end

    if (cmd_i.tgt_en) begin
      tgt_d   = tc;
      phase_d = PH_READY;
    end

    if (cmd_i.fin_en) begin
      if (disp > DW'(tv_q)) begin
        rem_d = '0;
      end else begin
        rem_d = tv_q - disp[VOL_W-1:0];
      end
      if (edge_q >= tgt_q) begin
        phase_d = PH_STOP;
        rem_d   = '0;
        done_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_STOP;
      cd_q    <= '0;
      tv_q    <= '0;
      tgt_q   <= '0;
      unit_q  <= '0;
      edge_q  <= '0;
      rem_q   <= '0;
      prev_q  <= 1'b0;
      qual_q  <= 1'b0;
      hr_q    <= '0;
      lr_q    <= '0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cd_q    <= cd_d;
      tv_q    <= tv_d;
      tgt_q   <= tgt_d;
      unit_q  <= unit_d;
      edge_q  <= edge_d;
      rem_q   <= rem_d;
      prev_q  <= prev_d;
      qual_q  <= qual_d;
      hr_q    <= hr_d;
      lr_q    <= lr_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    dr_q  <= dr_d;
    cnt_q <= cnt_d;
    if (cmd_i.mul_en) begin
      prod_q <= PW'(edge_q) * PW'(unit_q);
    end
  end

  assign edge_ext = EX_W'(edge_q);

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      pump_on_o      <= (phase_q == PH_OPEN);
      phase_o        <= phase_q;
      remaining_ml_o <= rem_q;
      flow_count_o   <= edge_ext[FLOW_W-1:0];
      done_res_o     <= done_q;
    end
  end

  assign sts_o.is_stop  = (phase_q == PH_STOP);
  assign sts_o.is_open  = (phase_q == PH_OPEN);
  assign sts_o.div_last = (cnt_q == CNT_W'(QW - 1));

endmodule

// File: rtl/fbdc_checker.sv
// port-level checker for the dispense controller and its bind
`timescale 1ns / 1ps
`include "flow_batch_dispense_controller_core_assert.svh"
module fbdc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic                            pump_on_o,
  input logic [fbdc_pkg::PHASE_W-1:0]    phase_o,
  input logic [fbdc_pkg::VOL_W-1:0]      remaining_ml_o,
  input logic [fbdc_pkg::FLOW_W-1:0]     flow_count_o,
  input logic                            done_res_o
);
  import fbdc_pkg::*;

  // one item at a time: busy right after an accept
  `FBDC_ASSERT_NEXT(a_busy_after_take, in_valid_i && in_ready_o, !in_ready_o, "accepted while busy")

  // a finished batch reports stopped with nothing left
  `FBDC_ASSERT_NOW(a_done_stops, out_valid_o && done_res_o, phase_o == PH_STOP && remaining_ml_o == '0, "done without stop")

  // pump drive follows the open phase
  `FBDC_ASSERT_NOW(a_pump_phase, out_valid_o, pump_on_o == (phase_o == PH_OPEN), "pump and phase disagree")

  // stalled result holds
  `FBDC_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(flow_count_o) && $stable(remaining_ml_o) && $stable(phase_o) && $stable(done_res_o), "result changed while stalled")

endmodule

bind flow_batch_dispense_controller_core fbdc_checker u_fbdc_checker (.*);

// File: test/tb.sv
// self-checking testbench for the flow-meter batch dispense controller
`timescale 1ns / 1ps
module tb;
  import fbdc_pkg::*;

  localparam int FRAC_BITS = 12;
  localparam logic [FLOW_W-1:0] EDGE_MAX = '1;
  localparam int HOLD_CYCLES = 300;

  // register settings as the block holds them, already cut to register width
  typedef struct packed {
    logic [UNIT_W-1:0] unit_small;
    logic [UNIT_W-1:0] unit_large;
    logic [VOL_W-1:0]  unit_thr;
    logic [VOL_W-1:0]  trim_thr;
    logic [TICK_W-1:0] ready_tck;
    logic [TICK_W-1:0] qual_tck;
    logic [TICK_W-1:0] glitch_tck;
  } disp_cfg_t;

  // one status item as the block reports it
  typedef struct packed {
    logic               pump_on;
    logic [PHASE_W-1:0] phase;
    logic [VOL_W-1:0]   remaining;
    logic [FLOW_W-1:0]  flow;
    logic               done;
  } disp_status_t;

  // block ports; the inputs are known from time zero
  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic                  mode_i = MODE_TICK;
  logic                  sensor_level_i = 1'b0;
  logic [VOL_W-1:0]      volume_ml_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic                  pump_on_o;
  logic [PHASE_W-1:0]    phase_o;
  logic [VOL_W-1:0]      remaining_ml_o;
  logic [FLOW_W-1:0]     flow_count_o;
  logic                  done_res_o;

  flow_batch_dispense_controller_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .sensor_level_i(sensor_level_i),
    .volume_ml_i   (volume_ml_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pump_on_o     (pump_on_o),
    .phase_o       (phase_o),
    .remaining_ml_o(remaining_ml_o),
    .flow_count_o  (flow_count_o),
    .done_res_o    (done_res_o)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow copy of the controller: settings start at their reset values
  disp_cfg_t cfg_m = '{RST_UNIT_SMALL, RST_UNIT_LARGE, RST_UNIT_THR, RST_TRIM_THR,
                       RST_READY_TCK, RST_QUAL_TCK, RST_GLITCH_TCK};
  logic [PHASE_W-1:0] st_phase = PH_STOP;
  logic [TICK_W-1:0]  st_countdown = '0;
  logic [VOL_W-1:0]   st_tgt_vol = '0;
  logic [FLOW_W-1:0]  st_tgt_cnt = '0;
  logic [UNIT_W-1:0]  st_unit = '0;
  logic [FLOW_W-1:0]  st_edges = '0;
  logic [VOL_W-1:0]   st_remain = '0;
  logic               st_prev = 1'b0;
  logic               st_qual = 1'b0;
  logic [TICK_W-1:0]  st_run_hi = '0;
  logic [TICK_W-1:0]  st_run_lo = '0;

  // status items still owed by the block, oldest first
  disp_status_t expected_status_q[$];

  int n_errors = 0;
  int n_items = 0;
  int n_done = 0;
  int n_stops = 0;
  int n_settings = 0;

  // idling controls shared by the test tasks and both sides
  bit src_idle = 1'b0;
  bit sink_idle = 1'b0;
  int sink_hold = 0;

  function automatic int draw_gap(input bit on);
    return on ? $urandom_range(0, 18) : 0;
  endfunction

  // meter edge qualifier: a level counts once it has held for qual_tck ticks,
  // and a too short opposite run is dropped when the level flips back
  function automatic void qualify_level(input logic lvl);
    if (lvl) begin
      if (!st_prev && st_qual && st_run_lo < cfg_m.glitch_tck) st_run_lo = '0;
      if (!st_qual) begin
        if (st_run_hi != 8'hff) st_run_hi = st_run_hi + 8'd1;
        if (st_run_hi >= cfg_m.qual_tck) begin
          st_run_hi = '0;
          st_qual = 1'b1;
          if (st_edges != EDGE_MAX) st_edges = st_edges + 1'b1;
        end
      end
      st_prev = 1'b1;
    end else begin
      if (st_prev && !st_qual && st_run_hi < cfg_m.glitch_tck) st_run_hi = '0;
      if (st_qual) begin
        if (st_run_lo != 8'hff) st_run_lo = st_run_lo + 8'd1;
        if (st_run_lo >= cfg_m.qual_tck) begin
          st_run_lo = '0;
          st_qual = 1'b0;
          if (st_edges != EDGE_MAX) st_edges = st_edges + 1'b1;
        end
      end
      st_prev = 1'b0;
    end
  endfunction

  // advances the shadow controller by one item and returns its status
  function automatic disp_status_t predict_status(input logic mode, input logic lvl,
                                                  input logic [VOL_W-1:0] vol);
    disp_status_t r;
    logic [63:0]  v64, u64, e64, tc, disp;
    logic         done;
    done = 1'b0;
    if (mode == MODE_PRESS) begin
      if (st_phase == PH_STOP) begin
        // start press: pick the unit and round volume / unit
        st_unit = (vol <= cfg_m.unit_thr) ? cfg_m.unit_small : cfg_m.unit_large;
        v64 = vol;
        u64 = st_unit;
        if (st_unit == '0) begin
          tc = EDGE_MAX;
        end else begin
          tc = ((v64 << (FRAC_BITS + 1)) + u64) / (u64 << 1);
          if (tc > EDGE_MAX) tc = EDGE_MAX;
        end
        // trim never takes a zero target below zero
        if (vol <= cfg_m.trim_thr && tc != 0) tc = tc - 1;
        st_tgt_cnt = tc[FLOW_W-1:0];
        st_tgt_vol = vol;
        st_remain = vol;
        st_countdown = cfg_m.ready_tck;
        st_phase = PH_READY;
      end else begin
        // stop press: remaining and count are held
        st_phase = PH_STOP;
        n_stops++;
      end
    end else if (st_phase == PH_READY) begin
      // countdown wraps, so a zero setting waits 256 ticks; no level sampled here
      st_countdown = st_countdown - 8'd1;
      if (st_countdown == '0) begin
        st_phase = PH_OPEN;
        st_edges = '0;
        st_prev = 1'b0;
        st_qual = 1'b0;
        st_run_hi = '0;
        st_run_lo = '0;
      end
    end else if (st_phase == PH_OPEN) begin
      qualify_level(lvl);
      e64 = st_edges;
      u64 = st_unit;
      v64 = st_tgt_vol;
      disp = (e64 * u64) >> FRAC_BITS;
      if (disp > v64) disp = v64;
      st_remain = st_tgt_vol - disp[VOL_W-1:0];
      if (st_edges >= st_tgt_cnt) begin
        st_phase = PH_STOP;
        st_remain = '0;
        done = 1'b1;
        n_done++;
      end
    end
    // a tick while stopped leaves everything as it is
    r.pump_on = (st_phase == PH_OPEN);
    r.phase = st_phase;
    r.remaining = st_remain;
    r.flow = st_edges;
    r.done = done;
    return r;
  endfunction

  // offers one item after a random gap and records what it must produce;
  // valid stays high on return so a back-to-back item keeps it up
  task automatic send_item(input logic mode, input logic lvl, input logic [VOL_W-1:0] vol);
    int gap;
    gap = draw_gap(src_idle);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= mode;
    sensor_level_i <= lvl;
    volume_ml_i <= vol;
    do @(posedge clk_i); while (!in_ready_o);
    expected_status_q.push_back(predict_status(mode, lvl, vol));
    n_items++;
  endtask

  // lets every owed status item arrive, then a margin for the core to go quiet
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_status_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // stops any batch, waits until idle, then writes all seven registers;
  // unused upper data bits carry random junk that the block must ignore
  task automatic load_regs(input logic [UNIT_W-1:0] u_small, input logic [UNIT_W-1:0] u_large,
                           input logic [VOL_W-1:0] u_thr, input logic [VOL_W-1:0] t_thr,
                           input logic [TICK_W-1:0] rdy, input logic [TICK_W-1:0] qual,
                           input logic [TICK_W-1:0] glitch);
    logic [31:0] junk;
    junk = $urandom;
    if (st_phase != PH_STOP) send_item(MODE_PRESS, junk[0], junk[VOL_W:1]);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_UNIT_SMALL;
    cfg_wdata_i <= u_small;
    @(posedge clk_i);
    cfg_idx_i <= REG_UNIT_LARGE;
    cfg_wdata_i <= u_large;
    @(posedge clk_i);
    cfg_idx_i <= REG_UNIT_THR;
    cfg_wdata_i <= {junk[15], u_thr};
    @(posedge clk_i);
    cfg_idx_i <= REG_TRIM_THR;
    cfg_wdata_i <= {junk[14], t_thr};
    @(posedge clk_i);
    cfg_idx_i <= REG_READY_TCK;
    cfg_wdata_i <= {junk[31:24], rdy};
    @(posedge clk_i);
    cfg_idx_i <= REG_QUAL_TCK;
    cfg_wdata_i <= {junk[23:16], qual};
    @(posedge clk_i);
    cfg_idx_i <= REG_GLITCH_TCK;
    cfg_wdata_i <= {junk[27:20], glitch};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_m = '{u_small, u_large, u_thr, t_thr, rdy, qual, glitch};
    n_settings++;
  endtask

  // random batches: mostly start, ready ticks and open ticks with level runs
  // around the qualify and glitch lengths, plus aborts and stray ticks
  task automatic run_batches(input int budget);
    int          counted, ticks, cap, run_left, v, vcap, ready_len;
    logic        lvl;
    logic [31:0] r32;
    counted = 0;
    ticks = 0;
    cap = 0;
    run_left = 0;
    lvl = 1'b0;
    ready_len = (cfg_m.ready_tck == '0) ? 256 : cfg_m.ready_tck;
    // volumes up to this size finish in a handful of counts
    vcap = ((cfg_m.unit_small + cfg_m.unit_large) * 3) >> FRAC_BITS;
    if (vcap < 3) vcap = 3;
    while (counted < budget) begin
      r32 = $urandom;
      if (st_phase == PH_STOP) begin
        if ($urandom_range(0, 7) == 0) begin
          // ignored by the block, so not counted
          send_item(MODE_TICK, r32[0], r32[VOL_W:1]);
        end else begin
          case ($urandom_range(0, 9))
            6:       v = cfg_m.unit_thr + $urandom_range(0, 2) - 1;
            7:       v = cfg_m.trim_thr + $urandom_range(0, 2) - 1;
            8:       v = $urandom_range(0, 19998);
            9:       v = $urandom_range(0, 32767);
            default: v = $urandom_range(0, vcap);
          endcase
          if (v < 0) v = 0;
          if (v > 32767) v = 32767;
          send_item(MODE_PRESS, r32[0], v[VOL_W-1:0]);
          counted++;
          ticks = 0;
          cap = ready_len + $urandom_range(10, 3 * cfg_m.qual_tck + 30);
        end
      end else if (ticks >= cap || $urandom_range(0, 79) == 0) begin
        // abort a long batch, or now and then any batch
        send_item(MODE_PRESS, r32[0], r32[VOL_W:1]);
        counted++;
      end else begin
        if (run_left == 0) begin
          lvl = ~lvl;
          if ($urandom_range(0, 3) == 0)
            run_left = $urandom_range(1, cfg_m.glitch_tck + 1);
          else
            run_left = $urandom_range(1, cfg_m.qual_tck + cfg_m.glitch_tck + 3);
        end
        send_item(MODE_TICK, lvl, r32[VOL_W:1]);
        run_left--;
        ticks++;
        counted++;
      end
    end
  endtask

  // random batches under the reset settings, before any register write
  task automatic test_reset_settings();
    src_idle = 1'b1;
    sink_idle = 1'b1;
    run_batches(250);
  endtask

  // hand-picked items: unit choice and trim at their thresholds, zero volume,
  // widest volume, zero unit, saturated target, glitch drop, stop while ready and while open
  task automatic test_directed_cases();
    src_idle = 1'b0;
    sink_idle = 1'b0;
    load_regs(16'd65535, 16'd40000, 15'd100, 15'd10, 8'd1, 8'd1, 8'd0);
    send_item(MODE_TICK, 1'b1, 15'h7fff);    // tick while stopped
    send_item(MODE_PRESS, 1'b0, 15'd0);      // zero target
    send_item(MODE_TICK, 1'b1, 15'd0);       // opens
    send_item(MODE_TICK, 1'b0, 15'd0);       // done at once
    send_item(MODE_PRESS, 1'b1, 15'd10);     // trim takes target one to zero
    send_item(MODE_TICK, 1'b0, 15'd0);
    send_item(MODE_TICK, 1'b1, 15'd0);       // edge and done together
    send_item(MODE_PRESS, 1'b0, 15'd100);    // at threshold, small unit
    send_item(MODE_TICK, 1'b0, 15'd0);
    send_item(MODE_TICK, 1'b1, 15'd0);
    send_item(MODE_TICK, 1'b0, 15'd0);
    send_item(MODE_PRESS, 1'b1, 15'd0);      // stop while open
    send_item(MODE_PRESS, 1'b0, 15'd101);    // above threshold, large unit
    send_item(MODE_PRESS, 1'b0, 15'd0);      // stop while ready
    send_item(MODE_PRESS, 1'b1, 15'h7fff);   // widest volume
    send_item(MODE_TICK, 1'b1, 15'd0);
    send_item(MODE_PRESS, 1'b0, 15'd0);
    load_regs(16'd0, 16'd1, 15'd19998, 15'd0, 8'd2, 8'd2, 8'd2);
    send_item(MODE_PRESS, 1'b0, 15'd5);      // zero unit saturates the target
    send_item(MODE_TICK, 1'b1, 15'd0);
    send_item(MODE_TICK, 1'b1, 15'd0);
    send_item(MODE_TICK, 1'b1, 15'd0);
    send_item(MODE_TICK, 1'b0, 15'd0);       // short high run dropped
    send_item(MODE_TICK, 1'b1, 15'd0);
    send_item(MODE_TICK, 1'b1, 15'd0);
    send_item(MODE_PRESS, 1'b0, 15'd0);
    send_item(MODE_PRESS, 1'b0, 15'd20000);  // unit one, target beyond width
    send_item(MODE_PRESS, 1'b0, 15'd0);
  endtask

  // each register near one end of its range, then near the other end
  task automatic test_extreme_settings();
    src_idle = 1'b1;
    sink_idle = 1'b0;
    load_regs(16'd256, 16'd65535, 15'd0, 15'd0, 8'd0, 8'd1, 8'd0);
    run_batches(380);
    src_idle = 1'b0;
    sink_idle = 1'b1;
    load_regs(16'd65535, 16'd256, 15'd19998, 15'h7fff, 8'd255, 8'd255, 8'd255);
    run_batches(400);
  endtask

  // short timers and random units so that most batches run to the end
  task automatic test_random_settings();
    logic [UNIT_W-1:0] u_small, u_large;
    logic [VOL_W-1:0]  u_thr, t_thr;
    logic [TICK_W-1:0] rdy, qual, glitch;
    for (int k = 0; k < 6; k++) begin
      u_small = UNIT_W'($urandom_range(0, 1) ? $urandom_range(8192, 65535)
                                             : $urandom_range(256, 65535));
      u_large = UNIT_W'($urandom_range(0, 1) ? $urandom_range(8192, 65535)
                                             : $urandom_range(256, 65535));
      u_thr = VOL_W'($urandom_range(0, 1) ? $urandom_range(0, 400)
                                          : $urandom_range(0, 19998));
      t_thr = VOL_W'($urandom_range(0, 1) ? $urandom_range(0, 100)
                                          : $urandom_range(0, 19998));
      rdy = TICK_W'($urandom_range(1, 6));
      qual = TICK_W'($urandom_range(1, 6));
      glitch = TICK_W'($urandom_range(0, 8));
      load_regs(u_small, u_large, u_thr, t_thr, rdy, qual, glitch);
      src_idle = $urandom_range(0, 1);
      sink_idle = $urandom_range(0, 1);
      run_batches(110);
    end
  endtask

  // receiver holds off for a long stretch while items keep coming back to back
  task automatic test_output_backpressure();
    load_regs(16'd40000, 16'd40000, 15'd300, 15'd50, 8'd2, 8'd2, 8'd1);
    src_idle = 1'b0;
    sink_idle = 1'b0;
    sink_hold = HOLD_CYCLES;
    send_item(MODE_PRESS, 1'b0, 15'd2000);
    for (int k = 0; k < 24; k++) send_item(MODE_TICK, k[1], 15'd0);
    send_item(MODE_PRESS, 1'b1, 15'd0);
  endtask

  task automatic test_wrapup();
    drain_results();
    $display("covered %0d items over %0d register settings", n_items, n_settings);
    $display("%0d batches reached their target, %0d stopped by a press", n_done, n_stops);
    if (n_errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  endtask

  // one field of a status item against its prediction
  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      n_errors++;
    end
  endtask

  // receiver: random ready gaps, one long hold when asked, checks in order
  initial begin : result_check
    disp_status_t want, got;
    int           gap;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (sink_hold > 0) begin
        gap = sink_hold;
        sink_hold = 0;
      end else begin
        gap = draw_gap(sink_idle);
      end
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got.pump_on = pump_on_o;
      got.phase = phase_o;
      got.remaining = remaining_ml_o;
      got.flow = flow_count_o;
      got.done = done_res_o;
      if (expected_status_q.size() == 0) begin
        $display("%0t: status item with nothing expected, phase %0d flow %0d", $time,
                 got.phase, got.flow);
        n_errors++;
      end else begin
        want = expected_status_q.pop_front();
        report_field("pump_on", want.pump_on, got.pump_on);
        report_field("phase", want.phase, got.phase);
        report_field("remaining_ml", want.remaining, got.remaining);
        report_field("flow_count", want.flow, got.flow);
        report_field("done_res", want.done, got.done);
      end
    end
  end

  // stimulus: reset once, then each test in turn
  initial begin : stimulus
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_settings();
    test_directed_cases();
    test_extreme_settings();
    test_random_settings();
    test_output_backpressure();
    test_wrapup();
  end

  // run limit, several times the slowest legal run
  initial begin : watchdog
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/fbdc_pkg.sv
rtl/fbdc_ctrl.sv
rtl/fbdc_datapath.sv
rtl/flow_batch_dispense_controller_core.sv
rtl/fbdc_checker.sv
test/tb.sv
